/* rtl/core/acal_pkg.sv */
package acal_pkg;

  localparam int CODE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VALUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VALUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP      = 3'd5;

  localparam logic signed [VALUE_W-1:0] SAT16_MAX = 32'sd32767;
  localparam logic signed [VALUE_W-1:0] SAT16_MIN = -32'sd32768;

  typedef struct packed {
    logic [CODE_W-1:0]  low_code;
    logic [CODE_W-1:0]  zero_code;
    logic [CODE_W-1:0]  high_code;
    logic [VALUE_W-1:0] low_value;
    logic [VALUE_W-1:0] high_value;
    logic               clamp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    low_code:   16'd0,
    zero_code:  16'd0,
    high_code:  16'hFFFF,
    low_value:  32'd0,
    high_value: 32'd32767,
    clamp:      1'b0
  };

  // Where a code falls on the calibration curve
  typedef enum logic [2:0] {
    REG_INVALID,
    REG_LOW,
    REG_HIGH,
    REG_ZERO,
    REG_SEG_LO,
    REG_SEG_HI
  } region_t;

  typedef struct packed {
    region_t region;
    logic    neg;
  } ctl_t;

endpackage

/* rtl/core/acal_front.sv */
module acal_front #(
  parameter int CODE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [acal_pkg::CODE_W-1:0]            in_code,
  input  acal_pkg::cfg_t                         cfg,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [acal_pkg::VALUE_W+CODE_BITS-1:0] out_num,
  output logic [CODE_BITS-1:0]                   out_span,
  output acal_pkg::ctl_t                         out_ctl
);

  localparam int NUM_W = acal_pkg::VALUE_W + CODE_BITS;

  logic [CODE_BITS-1:0] code, lo, ze, hi;
  logic                 bad;
  acal_pkg::ctl_t       ctl_nxt;
  logic [CODE_BITS-1:0] off_nxt, span_nxt;
  logic [acal_pkg::VALUE_W-1:0] mag_nxt;

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2, rdy3;
  acal_pkg::ctl_t       ctl1_r, ctl2_r, ctl3_r;
  logic [CODE_BITS-1:0] off1_r, span1_r, span2_r, span3_r;
  logic [acal_pkg::VALUE_W-1:0] mag1_r;
  logic [NUM_W-1:0]     prod2_r, num3_r;

  assign code = in_code[CODE_BITS-1:0];
  assign lo   = cfg.low_code[CODE_BITS-1:0];
  assign ze   = cfg.zero_code[CODE_BITS-1:0];
  assign hi   = cfg.high_code[CODE_BITS-1:0];
  assign bad  = (lo > ze) || (ze >= hi);

  always_comb begin
    ctl_nxt.neg = 1'b0;
    off_nxt     = '0;
    span_nxt    = CODE_BITS'(1);
    mag_nxt     = '0;
    priority if (bad) begin
      ctl_nxt.region = acal_pkg::REG_INVALID;
    end else if (code <= lo) begin
      ctl_nxt.region = acal_pkg::REG_LOW;
    end else if (code >= hi) begin
      ctl_nxt.region = acal_pkg::REG_HIGH;
    end else if (code == ze) begin
      ctl_nxt.region = acal_pkg::REG_ZERO;
    end else if (code < ze) begin
      // slope runs from low_value up or down to zero
      ctl_nxt.region = acal_pkg::REG_SEG_LO;
      ctl_nxt.neg    = ~cfg.low_value[acal_pkg::VALUE_W-1] && (cfg.low_value != '0);
      off_nxt        = code - lo;
      span_nxt       = ze - lo;
      mag_nxt        = cfg.low_value[acal_pkg::VALUE_W-1] ?
                       (~cfg.low_value + 32'd1) : cfg.low_value;
    end else begin
      ctl_nxt.region = acal_pkg::REG_SEG_HI;
      ctl_nxt.neg    = cfg.high_value[acal_pkg::VALUE_W-1];
      off_nxt        = code - ze;
      span_nxt       = hi - ze;
      mag_nxt        = cfg.high_value[acal_pkg::VALUE_W-1] ?
                       (~cfg.high_value + 32'd1) : cfg.high_value;
    end
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ctl1_r  <= ctl_nxt;
      off1_r  <= off_nxt;
      span1_r <= span_nxt;
      mag1_r  <= mag_nxt;
    end
    if (rdy2 && v1_r) begin
      ctl2_r  <= ctl1_r;
      span2_r <= span1_r;
      prod2_r <= NUM_W'(mag1_r) * NUM_W'(off1_r);
    end
    if (rdy3 && v2_r) begin
      // add half the span so the quotient magnitude rounds half away from zero
      ctl3_r  <= ctl2_r;
      span3_r <= span2_r;
      num3_r  <= prod2_r + NUM_W'(span2_r >> 1);
    end
  end

  assign out_valid = v3_r;
  assign out_num   = num3_r;
  assign out_span  = span3_r;
  assign out_ctl   = ctl3_r;

endmodule

/* rtl/core/acal_div_step.sv */
module acal_div_step #(
  parameter int CODE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CODE_BITS-1:0]          in_rem,
  input  logic [acal_pkg::VALUE_W-1:0]  in_word,
  input  logic [CODE_BITS-1:0]          in_span,
  input  acal_pkg::ctl_t                in_ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CODE_BITS-1:0]          out_rem,
  output logic [acal_pkg::VALUE_W-1:0]  out_word,
  output logic [CODE_BITS-1:0]          out_span,
  output acal_pkg::ctl_t                out_ctl
);

  logic                         vld_r;
  logic [CODE_BITS-1:0]         rem_r, span_r;
  logic [acal_pkg::VALUE_W-1:0] word_r;
  acal_pkg::ctl_t               ctl_r;
  logic [CODE_BITS:0]           trial, diff;
  logic                         ge;
  logic [CODE_BITS-1:0]         rem_nxt;
  logic [acal_pkg::VALUE_W-1:0] word_nxt;

  // shift one numerator bit in, subtract when it fits, shift the quotient bit in
  assign trial    = {in_rem, in_word[acal_pkg::VALUE_W-1]};
  assign diff     = trial - {1'b0, in_span};
  assign ge       = trial >= {1'b0, in_span};
  assign rem_nxt  = ge ? diff[CODE_BITS-1:0] : trial[CODE_BITS-1:0];
  assign word_nxt = {in_word[acal_pkg::VALUE_W-2:0], ge};

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      word_r <= word_nxt;
      span_r <= in_span;
      ctl_r  <= in_ctl;
    end
  end

  assign out_valid = vld_r;
  assign out_rem   = rem_r;
  assign out_word  = word_r;
  assign out_span  = span_r;
  assign out_ctl   = ctl_r;

`ifndef SYNTHESIS
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (rem_r < span_r))
    else $error("remainder left its range");
`endif

endmodule

/* rtl/core/acal_back.sv */
module acal_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [acal_pkg::VALUE_W-1:0]  in_quot,
  input  acal_pkg::ctl_t                in_ctl,
  input  acal_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acal_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_invalid
);

  logic                         v1_r, v2_r, rdy1, rdy2;
  logic [acal_pkg::VALUE_W-1:0] val_nxt, val1_r, val2_r, sat_nxt;
  logic                         inv1_r, inv2_r;

  always_comb begin
    unique case (in_ctl.region)
      acal_pkg::REG_LOW:    val_nxt = cfg.low_value;
      acal_pkg::REG_HIGH:   val_nxt = cfg.high_value;
      acal_pkg::REG_SEG_LO: val_nxt = in_ctl.neg ? (cfg.low_value - in_quot)
                                                 : (cfg.low_value + in_quot);
      acal_pkg::REG_SEG_HI: val_nxt = in_ctl.neg ? (32'd0 - in_quot) : in_quot;
      default:              val_nxt = '0;
    endcase
  end

  always_comb begin
    priority if (cfg.clamp && ($signed(val1_r) > acal_pkg::SAT16_MAX)) begin
      sat_nxt = acal_pkg::SAT16_MAX;
    end else if (cfg.clamp && ($signed(val1_r) < acal_pkg::SAT16_MIN)) begin
      sat_nxt = acal_pkg::SAT16_MIN;
    end else begin
      sat_nxt = val1_r;
    end
  end

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      val1_r <= val_nxt;
      inv1_r <= (in_ctl.region == acal_pkg::REG_INVALID);
    end
    if (rdy2 && v1_r) begin
      val2_r <= sat_nxt;
      inv2_r <= inv1_r;
    end
  end

  assign out_valid   = v2_r;
  assign out_value   = val2_r;
  assign out_invalid = inv2_r;

endmodule

/* rtl/core/adc_three_point_calibration.sv */
// Three-point ADC calibration: maps each raw converter code onto a calibrated
// signed value through the points (low_code, low_value), (zero_code, 0) and
// (high_code, high_value), interpolating linearly (halves away from zero above
// zero_code, toward zero below), optionally saturated to signed 16 bits.
//
// Input stream: in_tdata carries one raw code per word.
// Output stream: out_tdata carries the calibrated value, out_tuser flags an
// invalid calibration (low_code > zero_code or zero_code >= high_code), in
// which case the value is zero.
// Config port: cfg_we writes cfg_wdata to register cfg_addr;
// write only while no word is in flight.
//
// The pipeline has three front stages (decode, multiply, rounding add), 32
// restoring divider stages that each settle one quotient bit, and two back
// stages (offset, saturate). Throughput is one word per cycle while out_tready
// is high; each stage holds its own valid bit.
// A stalled receiver holds the output word; stages behind it keep filling
// bubbles and in_tready drops only once every stage holds a word.
// Reset clears all valid bits and loads the register defaults.
module adc_three_point_calibration #(
  parameter int CODE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] raw_code
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // [31:0] calibrated_value
  output logic                               out_tuser,  // [0] calibration_invalid
  input  logic                               cfg_we,
  input  logic [acal_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [31:0]                        cfg_wdata
);

  localparam int NUM_W = acal_pkg::VALUE_W + CODE_BITS;
  localparam int STEPS = acal_pkg::VALUE_W;

  acal_pkg::cfg_t cfg_r;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= acal_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acal_pkg::CFG_LOW_CODE:   cfg_r.low_code   <= cfg_wdata[acal_pkg::CODE_W-1:0];
        acal_pkg::CFG_ZERO_CODE:  cfg_r.zero_code  <= cfg_wdata[acal_pkg::CODE_W-1:0];
        acal_pkg::CFG_HIGH_CODE:  cfg_r.high_code  <= cfg_wdata[acal_pkg::CODE_W-1:0];
        acal_pkg::CFG_LOW_VALUE:  cfg_r.low_value  <= cfg_wdata;
        acal_pkg::CFG_HIGH_VALUE: cfg_r.high_value <= cfg_wdata;
        acal_pkg::CFG_CLAMP:      cfg_r.clamp      <= cfg_wdata[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front end to divider
  logic                 f_valid, f_ready;
  logic [NUM_W-1:0]     f_num;
  logic [CODE_BITS-1:0] f_span;
  acal_pkg::ctl_t       f_ctl;

  acal_front #(.CODE_BITS(CODE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_code   (in_tdata),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_num   (f_num),
    .out_span  (f_span),
    .out_ctl   (f_ctl)
  );

  // Divider chain: node 0 is the front end, node STEPS the last step.
  // The quotient fits 32 bits, so the top CODE_BITS numerator bits seed the
  // remainder and the low 32 bits shift through as the quotient forms.
  logic                         d_valid [STEPS+1];
  logic                         d_ready [STEPS+1];
  logic [CODE_BITS-1:0]         d_rem   [STEPS+1];
  logic [acal_pkg::VALUE_W-1:0] d_word  [STEPS+1];
  logic [CODE_BITS-1:0]         d_span  [STEPS+1];
  acal_pkg::ctl_t               d_ctl   [STEPS+1];

  assign d_valid[0] = f_valid;
  assign f_ready    = d_ready[0];
  assign d_rem[0]   = f_num[NUM_W-1 -: CODE_BITS];
  assign d_word[0]  = f_num[acal_pkg::VALUE_W-1:0];
  assign d_span[0]  = f_span;
  assign d_ctl[0]   = f_ctl;

  for (genvar i = 0; i < STEPS; i++) begin : g_div
    acal_div_step #(.CODE_BITS(CODE_BITS)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_valid[i]),
      .in_ready  (d_ready[i]),
      .in_rem    (d_rem[i]),
      .in_word   (d_word[i]),
      .in_span   (d_span[i]),
      .in_ctl    (d_ctl[i]),
      .out_valid (d_valid[i+1]),
      .out_ready (d_ready[i+1]),
      .out_rem   (d_rem[i+1]),
      .out_word  (d_word[i+1]),
      .out_span  (d_span[i+1]),
      .out_ctl   (d_ctl[i+1])
    );
  end

  acal_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d_valid[STEPS]),
    .in_ready    (d_ready[STEPS]),
    .in_quot     (d_word[STEPS]),
    .in_ctl      (d_ctl[STEPS]),
    .cfg         (cfg_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_tdata),
    .out_invalid (out_tuser)
  );

  // Final remainder and unused span of the last step are not needed
  logic unused_tail;
  assign unused_tail = ^{d_rem[STEPS], d_span[STEPS]};

`ifndef SYNTHESIS
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("invalid calibration with nonzero value");

  a_flag_matches_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ==
      ((cfg_r.low_code[CODE_BITS-1:0] > cfg_r.zero_code[CODE_BITS-1:0]) ||
       (cfg_r.zero_code[CODE_BITS-1:0] >= cfg_r.high_code[CODE_BITS-1:0]))))
    else $error("invalid flag disagrees with code ordering");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg_r.clamp) |->
      (($signed(out_tdata) <= acal_pkg::SAT16_MAX) &&
       ($signed(out_tdata) >= acal_pkg::SAT16_MIN)))
    else $error("saturated value out of 16 bit range");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// One expected calibrated word: value plus the invalid-calibration flag
typedef struct {
  logic [acal_pkg::VALUE_W-1:0] value;
  logic                         invalid;
} calib_word_t;

class calib_scoreboard;
  logic [acal_pkg::CODE_W-1:0] low_code;
  logic [acal_pkg::CODE_W-1:0] zero_code;
  logic [acal_pkg::CODE_W-1:0] high_code;
  longint            low_value;
  longint            high_value;
  logic              clamp;
  calib_word_t       expected_q[$];
  int                errors;

  function new();
    low_code   = acal_pkg::CFG_RESET.low_code;
    zero_code  = acal_pkg::CFG_RESET.zero_code;
    high_code  = acal_pkg::CFG_RESET.high_code;
    low_value  = longint'(signed'(acal_pkg::CFG_RESET.low_value));
    high_value = longint'(signed'(acal_pkg::CFG_RESET.high_value));
    clamp      = acal_pkg::CFG_RESET.clamp;
    errors     = 0;
  endfunction

  function void write_reg(input logic [acal_pkg::CFG_IDX_W-1:0] idx,
                          input logic [acal_pkg::VALUE_W-1:0] data);
    case (idx)
      acal_pkg::CFG_LOW_CODE:   low_code   = data[acal_pkg::CODE_W-1:0];
      acal_pkg::CFG_ZERO_CODE:  zero_code  = data[acal_pkg::CODE_W-1:0];
      acal_pkg::CFG_HIGH_CODE:  high_code  = data[acal_pkg::CODE_W-1:0];
      acal_pkg::CFG_LOW_VALUE:  low_value  = longint'(signed'(data));
      acal_pkg::CFG_HIGH_VALUE: high_value = longint'(signed'(data));
      acal_pkg::CFG_CLAMP:      clamp      = data[0];
      default: ;
    endcase
  endfunction

  // v0 + round(dv * off / span), halves away from zero
  function longint interpolate(input longint off, input longint span, input longint v0,
                               input longint dv);
    longint mag;
    longint q;
    mag = (dv < 0) ? -dv : dv;
    q   = (mag * off + span / 2) / span;
    return (dv < 0) ? v0 - q : v0 + q;
  endfunction

  function calib_word_t calibrate(input logic [acal_pkg::CODE_W-1:0] code);
    calib_word_t w;
    longint      v;
    w.invalid = (low_code > zero_code) || (zero_code >= high_code);
    if (w.invalid) begin
      w.value = '0;
      return w;
    end
    if (code <= low_code)
      v = low_value;
    else if (code >= high_code)
      v = high_value;
    else if (code == zero_code)
      v = 0;
    else if (code < zero_code)
      v = interpolate(longint'(code) - longint'(low_code),
                      longint'(zero_code) - longint'(low_code), low_value, -low_value);
    else
      v = interpolate(longint'(code) - longint'(zero_code),
                      longint'(high_code) - longint'(zero_code), 0, high_value);
    if (clamp) begin
      if (v > longint'(acal_pkg::SAT16_MAX))
        v = longint'(acal_pkg::SAT16_MAX);
      else if (v < longint'(acal_pkg::SAT16_MIN))
        v = longint'(acal_pkg::SAT16_MIN);
    end
    w.value = v[acal_pkg::VALUE_W-1:0];
    return w;
  endfunction

  function void note_code(input logic [acal_pkg::CODE_W-1:0] code);
    expected_q.push_back(calibrate(code));
  endfunction

  function void check_word(input logic [acal_pkg::VALUE_W-1:0] value, input logic invalid);
    calib_word_t w;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected word value=%0d invalid=%0b", $time, $signed(value), invalid);
      return;
    end
    w = expected_q.pop_front();
    if (value !== w.value) begin
      errors++;
      $display("%0t: calibrated_value expected %0d actual %0d", $time,
               $signed(w.value), $signed(value));
    end
    if (invalid !== w.invalid) begin
      errors++;
      $display("%0t: calibration_invalid expected %0b actual %0b", $time, w.invalid, invalid);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  // Indexes the block does not decode; writes there must change nothing
  localparam logic [acal_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [acal_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 40;    // settle time once every word is back
  localparam int PARK_CYCLES   = 300;   // long enough to fill every stage
  localparam int SETS_PER_MODE = 5;
  localparam int CODES_PER_SET = 63;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata = '0;      // [15:0] raw_code
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;          // [31:0] calibrated_value
  logic               out_tuser;          // [0] calibration_invalid
  logic               cfg_we = 1'b0;
  logic [acal_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [31:0]        cfg_wdata = '0;

  calib_scoreboard calib_sb = new();

  int src_idle_pct = 31;
  int snk_idle_pct = 81;
  int park_cycles  = 0;
  int cycle_count  = 0;

  adc_three_point_calibration #(
    .CODE_BITS(16)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: park for a counted stretch when asked, otherwise stall at random.
  initial begin
    forever begin
      @(posedge clk);
      if (park_cycles > 0) begin
        out_tready <= 1'b0;
        park_cycles--;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
      end
    end
  end

  // Sample mid-cycle: everything driven at the rising edge has settled and holds
  // until the next one, where the handshake actually happens.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      calib_sb.check_word(out_tdata, out_tuser);
  end

  // Offer one raw code; hold it until accepted, then log its expected word.
  task automatic send_code(input logic [acal_pkg::CODE_W-1:0] code);
    bit took;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do begin
      @(negedge clk);
      took = in_tvalid && in_tready;
      @(posedge clk);
    end while (!took);
    calib_sb.note_code(code);
  endtask

  // Drop the input, wait until every expected word is back, then wait out the settle time.
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    while (calib_sb.pending() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Keep cfg_we high across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [acal_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    calib_sb.write_reg(idx, data);
  endtask

  // Load a full calibration while the pipe is empty. Unused upper bits carry junk
  // since the block must ignore them.
  task automatic apply_calibration(input acal_pkg::cfg_t c, input bit hit_spare);
    drain(2);
    write_reg(acal_pkg::CFG_LOW_CODE,   {16'($urandom), c.low_code});
    write_reg(acal_pkg::CFG_ZERO_CODE,  {16'($urandom), c.zero_code});
    write_reg(acal_pkg::CFG_HIGH_CODE,  {16'($urandom), c.high_code});
    write_reg(acal_pkg::CFG_LOW_VALUE,  c.low_value);
    write_reg(acal_pkg::CFG_HIGH_VALUE, c.high_value);
    write_reg(acal_pkg::CFG_CLAMP,      {31'($urandom), c.clamp});
    if (hit_spare) begin
      write_reg(CFG_SPARE_A, $urandom);
      write_reg(CFG_SPARE_B, $urandom);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3, 0))
      0:       return $urandom;
      1:       return $urandom_range(70000, 0);
      2:       return 32'd0 - $urandom_range(70000, 0);
      default: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Mostly well-ordered calibrations, some with tiny spans; a few misordered.
  function automatic acal_pkg::cfg_t pick_calibration();
    acal_pkg::cfg_t c;
    int   kind;
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      c.low_code  = 16'($urandom);
      c.zero_code = 16'($urandom);
      c.high_code = 16'($urandom);
    end else if (kind <= 3) begin
      c.low_code  = 16'($urandom_range(65519, 0));
      c.zero_code = c.low_code + 16'($urandom_range(8, 0));
      c.high_code = c.zero_code + 16'($urandom_range(8, 1));
    end else begin
      c.low_code  = 16'($urandom_range(65534, 0));
      c.zero_code = 16'($urandom_range(65534, c.low_code));
      c.high_code = 16'($urandom_range(65535, c.zero_code + 1));
    end
    c.low_value  = pick_value();
    c.high_value = pick_value();
    c.clamp      = 1'($urandom_range(1, 0));
    return c;
  endfunction

  // Codes: uniform, inside the calibrated span, or right around a breakpoint.
  function automatic logic [acal_pkg::CODE_W-1:0] pick_code(input acal_pkg::cfg_t c);
    int pt;
    case ($urandom_range(3, 0))
      0, 1: return 16'($urandom_range(65535, 0));
      2:    return 16'($urandom_range(c.high_code, c.low_code));
      default: begin
        case ($urandom_range(2, 0))
          0:       pt = c.low_code;
          1:       pt = c.zero_code;
          default: pt = c.high_code;
        endcase
        pt = pt + $urandom_range(8, 0) - 4;
        if (pt < 0)
          pt = 0;
        if (pt > 65535)
          pt = 65535;
        return 16'(pt);
      end
    endcase
  endfunction

  initial begin
    acal_pkg::cfg_t c;
    int   mode;
    int   set;
    int   n;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: low and zero points coincide at code 0
    send_code(16'd0);
    send_code(16'd1);
    send_code(16'd16384);
    send_code(16'd32767);
    send_code(16'd32768);
    send_code(16'd65534);
    send_code(16'd65535);

    // Full-scale values on both ends; also poke the undecoded indexes
    c = '{low_code: 16'd1000, zero_code: 16'd30000, high_code: 16'd60000,
          low_value: 32'h8000_0000, high_value: 32'h7FFF_FFFF, clamp: 1'b0};
    apply_calibration(c, 1'b1);
    send_code(16'd0);
    send_code(16'd1000);
    send_code(16'd1001);
    send_code(16'd15500);
    send_code(16'd29999);
    send_code(16'd30000);
    send_code(16'd30001);
    send_code(16'd59999);
    send_code(16'd60000);
    send_code(16'd65535);

    // Same curve, saturated to 16 bits
    c.clamp = 1'b1;
    apply_calibration(c, 1'b0);
    send_code(16'd1001);
    send_code(16'd15500);
    send_code(16'd45000);
    send_code(16'd65535);

    // Exact halves on both segments: away from zero above, toward zero below
    c = '{low_code: 16'd0, zero_code: 16'd2, high_code: 16'd4,
          low_value: 32'hFFFF_FFFD, high_value: 32'd3, clamp: 1'b0};
    apply_calibration(c, 1'b0);
    send_code(16'd1);
    send_code(16'd3);

    // Misordered calibrations: low above zero, then zero equal to high
    c = '{low_code: 16'd500, zero_code: 16'd100, high_code: 16'd900,
          low_value: 32'd77, high_value: 32'd99, clamp: 1'b1};
    apply_calibration(c, 1'b0);
    send_code(16'd300);
    c = '{low_code: 16'd100, zero_code: 16'd900, high_code: 16'd900,
          low_value: 32'd77, high_value: 32'd99, clamp: 1'b0};
    apply_calibration(c, 1'b0);
    send_code(16'd900);

    // Random traffic: sender-light/receiver-heavy idling, the reverse, then none
    for (mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 81 : 0;
      snk_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 31 : 0;
      for (set = 0; set < SETS_PER_MODE; set++) begin
        c = pick_calibration();
        apply_calibration(c, set == 0);
        // Back-pressure: park the receiver while the sender streams at full rate
        if (mode == 2 && set == 0)
          park_cycles = PARK_CYCLES;
        for (n = 0; n < CODES_PER_SET; n++)
          send_code(pick_code(c));
      end
    end
    in_tvalid <= 1'b0;

    drain(DRAIN_CYCLES);
    if (calib_sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
